### hdl/lac_pkg.sv
// ============================================================================
// lac_pkg: shared types and constants of the layer alpha compositor
// Command kinds, back-end states, configuration view and blend helpers.
// ============================================================================
package lac_pkg;

  localparam int OUT_ROWS   = 256;
  localparam int DESC_COUNT = 4;
  localparam int Q_DEPTH    = 2;
  localparam int DIV_STEPS  = 9;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_COMP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [3:0] CFG_OUT_WIDTH  = 4'd0;
  localparam logic [3:0] CFG_OUT_HEIGHT = 4'd1;
  localparam logic [3:0] CFG_ZOOM       = 4'd2;
  localparam logic [3:0] CFG_WORLD      = 4'd3;
  localparam logic [3:0] CFG_LAYER0     = 4'd4;
  localparam logic [3:0] CFG_LAYER1     = 4'd5;
  localparam logic [3:0] CFG_LAYER2     = 4'd6;
  localparam logic [3:0] CFG_LAYER3     = 4'd7;

  typedef logic signed [17:0] coord_t;

  typedef enum logic [1:0] {
    K_WRITE,
    K_COMP,
    K_READ,
    K_ZERO
  } cmd_kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_DIV,
    ST_OCLR,
    ST_LSET1,
    ST_LSET2,
    ST_PRE,
    ST_PIX,
    ST_PWAIT,
    ST_PWB,
    ST_DONE
  } bst_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  sel;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] pix;
  } cmd_t;

  typedef struct packed {
    logic [8:0]                  ow;
    logic [8:0]                  oh;
    logic [15:0]                 zoom;
    logic [2:0]                  wcount;
    logic [DESC_COUNT-1:0][42:0] desc;
  } cfg_t;

  typedef struct packed {
    logic busy_clear;
    logic pop;
  } bk_stat_t;

  // exact v / 255 for v up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

endpackage

### hdl/lac_front.sv
// ============================================================================
// lac_front: input decode and command queue
// Classifies incoming items and holds them in a short queue for the back end.
// ============================================================================
module lac_front #(
  parameter int LAYERS           = 4,
  parameter int MAX_LAYER_WIDTH  = 256,
  parameter int MAX_LAYER_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,
  input  logic [3:0]        in_tuser,
  input  logic [8:0]        ow,
  input  logic [8:0]        oh,
  input  lac_pkg::bk_stat_t bk_stat,
  output lac_pkg::cmd_t     q_head,
  output logic              q_valid
);
  import lac_pkg::*;

  logic [1:0]  op;
  logic        keep;
  cmd_t        cmd;
  logic        push;
  cmd_t        q_mem [Q_DEPTH];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign op = in_tuser[1:0];

  always_comb begin
    cmd.sel  = in_tuser[3:2];
    cmd.x    = in_tdata[7:0];
    cmd.y    = in_tdata[15:8];
    cmd.pix  = in_tdata[47:16];
    cmd.kind = K_WRITE;
    keep     = 1'b0;
    case (op)
      OP_WRITE: begin
        keep = (int'(cmd.sel) < LAYERS) && (int'(cmd.x) < MAX_LAYER_WIDTH) &&
               (int'(cmd.y) < MAX_LAYER_HEIGHT);
      end
      OP_COMP: begin
        keep     = 1'b1;
        cmd.kind = K_COMP;
      end
      OP_READ: begin
        keep     = 1'b1;
        cmd.kind = ((9'(cmd.x) < ow) && (9'(cmd.y) < oh)) ? K_READ : K_ZERO;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_tready = !bk_stat.busy_clear && (cnt_r != 2'(Q_DEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_head    = q_mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (bk_stat.pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(bk_stat.pop);
    end
  end

endmodule

### hdl/lac_back.sv
// ============================================================================
// lac_back: command execution and frame composition
// Owns the layer and output stores, the composite sequencer and the result
// register.
// ============================================================================
module lac_back #(
  parameter int LAYERS           = 4,
  parameter int MAX_LAYER_WIDTH  = 256,
  parameter int MAX_LAYER_HEIGHT = 256,
  parameter int MAX_OUT_WIDTH    = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lac_pkg::cfg_t     cfg,
  input  lac_pkg::cmd_t     q_head,
  input  logic              q_valid,
  output lac_pkg::bk_stat_t bk_stat,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic [0:0]        out_tuser
);
  import lac_pkg::*;

  localparam int LWH    = MAX_LAYER_WIDTH * MAX_LAYER_HEIGHT;
  localparam int LDEPTH = LAYERS * LWH;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int ODEPTH = OUT_ROWS * MAX_OUT_WIDTH;
  localparam int OAW    = $clog2(ODEPTH);
  localparam int OXW    = $clog2(MAX_OUT_WIDTH);
  localparam int LIW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  bst_t state_r, state_nxt;
  logic pop;
  logic out_free;

  logic [LAW-1:0] clr_r;
  logic [LIW-1:0] li_r;
  logic [OXW-1:0] xcnt_r;
  logic [7:0]     ycnt_r;
  logic [3:0]     div_cnt_r;
  logic [15:0]    div_rem_r;
  logic [8:0]     div_q_r;

  logic [8:0]  w_r, h_r;
  logic        scaled_r;
  logic [24:0] swp_r, shp_r;
  coord_t      ox_r, oy_r, sw_r, sh_r, dx_r, dy_r;
  logic [19:0] sxq_r, syq_r;
  logic [15:0] sxr_r, syr_r;
  logic [19:0] sxq0_r;
  logic [15:0] sxr0_r;
  coord_t      pre_r;
  logic [OAW-1:0] oaddr_r;

  logic [31:0] lay_q_r, out_q_r;
  logic [3:0][15:0] prod_r;
  logic [31:0] src_r, dst_r;
  logic [7:0]  sa_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_done_r;

  logic [31:0] lmem [LDEPTH];
  logic [31:0] omem [ODEPTH];

  // descriptor decode
  logic [1:0]  li_ix;
  logic [42:0] d;
  logic        d_en, d_scaled, d_skip;
  logic [8:0]  d_w, d_h;
  coord_t      d_ox, d_oy;
  logic        last_layer;

  // walk
  coord_t      row, col, sw_c, sh_c, aw, ah;
  coord_t      nx, ny;
  logic        pre_done;
  logic        covered, last_x, last_y, frame_end;
  logic [8:0]  sx_sel, sy_sel;
  logic [LAW-1:0] laddr_pix, laddr_cmd, lwaddr;
  logic [OAW-1:0] oaddr_pix, oaddr_cmd, owaddr, oraddr;
  logic [8:0]  stq;
  logic [15:0] str;
  logic [16:0] sx_r2, sy_r2, rem_sh;
  logic        sx_ge, sy_ge;
  logic [19:0] step_sxq, step_syq;
  logic [15:0] step_sxr, step_syr;
  logic [OXW-1:0] adv_x;
  logic [7:0]  adv_y;
  logic [19:0] adv_sxq, adv_syq;
  logic [15:0] adv_sxr, adv_syr;
  logic        lwe, owe;
  logic [31:0] lwdata, owdata, blend_res;
  logic [7:0]  da;

  assign out_free = !out_valid_r || out_tready;

  assign li_ix      = 2'(li_r);
  assign d          = cfg.desc[li_ix];
  assign d_en       = d[42];
  assign d_w        = (int'(d[8:0]) > MAX_LAYER_WIDTH) ? 9'(MAX_LAYER_WIDTH) : d[8:0];
  assign d_h        = (int'(d[17:9]) > MAX_LAYER_HEIGHT) ? 9'(MAX_LAYER_HEIGHT) : d[17:9];
  assign d_ox       = $signed({{6{d[29]}}, d[29:18]});
  assign d_oy       = $signed({{6{d[41]}}, d[41:30]});
  assign d_scaled   = (int'(li_r) < int'(cfg.wcount)) && (cfg.zoom != 16'd256);
  assign d_skip     = !d_en || (d_w == 9'd0) || (d_h == 9'd0);
  assign last_layer = (li_r == LIW'(LAYERS - 1));

  assign sw_c = scaled_r ? $signed({1'b0, swp_r[24:8]}) : $signed(18'(w_r));
  assign sh_c = scaled_r ? $signed({1'b0, shp_r[24:8]}) : $signed(18'(h_r));
  assign aw   = $signed(18'(cfg.ow)) - ox_r;
  assign ah   = $signed(18'(cfg.oh)) - oy_r;

  assign row     = $signed(18'(ycnt_r)) - dy_r;
  assign col     = $signed(18'(xcnt_r)) - dx_r;
  assign covered = !row[17] && (row < sh_r) && !col[17] && (col < sw_r);
  assign last_x  = (9'(xcnt_r) == cfg.ow - 9'd1);
  assign last_y  = (9'(ycnt_r) == cfg.oh - 9'd1);
  assign frame_end = last_x && last_y;

  // source steps owed before column and row 0 when the layer starts left or above
  assign nx       = dx_r[17] ? -dx_r : '0;
  assign ny       = dy_r[17] ? -dy_r : '0;
  assign pre_done = (pre_r >= nx) && (pre_r >= ny);

  assign sx_sel = (sxq_r >= 20'(w_r)) ? (w_r - 9'd1) : sxq_r[8:0];
  assign sy_sel = (syq_r >= 20'(h_r)) ? (h_r - 9'd1) : syq_r[8:0];

  assign laddr_pix = LAW'(LWH * int'(li_r) + MAX_LAYER_WIDTH * int'(sy_sel) + int'(sx_sel));
  assign laddr_cmd = LAW'(LWH * int'(q_head.sel) + MAX_LAYER_WIDTH * int'(q_head.y) +
                          int'(q_head.x));
  assign oaddr_pix = OAW'(MAX_OUT_WIDTH * int'(ycnt_r) + int'(xcnt_r));
  assign oaddr_cmd = OAW'(MAX_OUT_WIDTH * int'(q_head.y) + int'(q_head.x));

  // incremental source coordinate: q += 256 / zoom, r += 256 % zoom when scaled, else q += 1
  assign stq   = scaled_r ? div_q_r : 9'd1;
  assign str   = scaled_r ? div_rem_r : 16'd0;
  assign sx_r2 = {1'b0, sxr_r} + {1'b0, str};
  assign sy_r2 = {1'b0, syr_r} + {1'b0, str};
  assign sx_ge = (sx_r2 >= {1'b0, cfg.zoom});
  assign sy_ge = (sy_r2 >= {1'b0, cfg.zoom});

  assign step_sxq = sxq_r + 20'(stq) + 20'(sx_ge);
  assign step_sxr = sx_ge ? 16'(sx_r2 - {1'b0, cfg.zoom}) : sx_r2[15:0];
  assign step_syq = syq_r + 20'(stq) + 20'(sy_ge);
  assign step_syr = sy_ge ? 16'(sy_r2 - {1'b0, cfg.zoom}) : sy_r2[15:0];

  always_comb begin
    adv_x   = xcnt_r + OXW'(1);
    adv_y   = ycnt_r;
    adv_sxq = sxq_r;
    adv_sxr = sxr_r;
    adv_syq = syq_r;
    adv_syr = syr_r;
    if (!col[17]) begin
      adv_sxq = step_sxq;
      adv_sxr = step_sxr;
    end
    if (last_x) begin
      adv_x   = '0;
      adv_sxq = sxq0_r;
      adv_sxr = sxr0_r;
      adv_y   = last_y ? 8'd0 : ycnt_r + 8'd1;
      if (!row[17]) begin
        adv_syq = step_syq;
        adv_syr = step_syr;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAW'(LDEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          case (q_head.kind)
            K_WRITE: pop = 1'b1;
            K_READ: begin
              if (out_free) begin
                pop       = 1'b1;
                state_nxt = ST_RD;
              end
            end
            K_ZERO: pop = out_free;
            K_COMP: begin
              if (out_free) begin
                pop       = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            default: pop = 1'b0;
          endcase
        end
      end
      ST_RD: state_nxt = ST_IDLE;
      ST_DIV: begin
        if (div_cnt_r == 4'(DIV_STEPS - 1)) begin
          state_nxt = ((cfg.ow == 9'd0) || (cfg.oh == 9'd0)) ? ST_DONE : ST_OCLR;
        end
      end
      ST_OCLR: begin
        if (frame_end) state_nxt = ST_LSET1;
      end
      ST_LSET1: begin
        if (d_skip) state_nxt = last_layer ? ST_DONE : ST_LSET1;
        else state_nxt = ST_LSET2;
      end
      ST_LSET2: state_nxt = ST_PRE;
      ST_PRE: begin
        if (pre_done) state_nxt = ST_PIX;
      end
      ST_PIX: begin
        if (covered) state_nxt = ST_PWAIT;
        else if (frame_end) state_nxt = last_layer ? ST_DONE : ST_LSET1;
      end
      ST_PWAIT: state_nxt = ST_PWB;
      ST_PWB: begin
        if (frame_end) state_nxt = last_layer ? ST_DONE : ST_LSET1;
        else state_nxt = ST_PIX;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign bk_stat.busy_clear = (state_r == ST_CLEAR);
  assign bk_stat.pop        = pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + LAW'(1);
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        div_cnt_r <= '0;
        div_rem_r <= '0;
        div_q_r   <= '0;
        xcnt_r    <= '0;
        ycnt_r    <= '0;
        li_r      <= '0;
      end
      ST_DIV: begin
        div_cnt_r <= div_cnt_r + 4'd1;
        if (rem_sh >= {1'b0, cfg.zoom}) begin
          div_rem_r <= 16'(rem_sh - {1'b0, cfg.zoom});
          div_q_r   <= {div_q_r[7:0], 1'b1};
        end else begin
          div_rem_r <= rem_sh[15:0];
          div_q_r   <= {div_q_r[7:0], 1'b0};
        end
      end
      ST_OCLR: begin
        xcnt_r <= adv_x;
        ycnt_r <= adv_y;
      end
      ST_LSET1: begin
        w_r      <= d_w;
        h_r      <= d_h;
        ox_r     <= d_ox;
        oy_r     <= d_oy;
        scaled_r <= d_scaled;
        swp_r    <= 25'(d_w * cfg.zoom);
        shp_r    <= 25'(d_h * cfg.zoom);
        if (d_skip) li_r <= li_r + LIW'(1);
      end
      ST_LSET2: begin
        sw_r   <= sw_c;
        sh_r   <= sh_c;
        dx_r   <= (scaled_r && (sw_c < aw)) ? ox_r + ((aw - sw_c) >>> 1) : ox_r;
        dy_r   <= (scaled_r && (sh_c < ah)) ? oy_r + ((ah - sh_c) >>> 1) : oy_r;
        xcnt_r <= '0;
        ycnt_r <= '0;
        sxq_r  <= '0;
        sxr_r  <= '0;
        syq_r  <= '0;
        syr_r  <= '0;
        sxq0_r <= '0;
        sxr0_r <= '0;
        pre_r  <= '0;
      end
      ST_PRE: begin
        if (!pre_done) pre_r <= pre_r + coord_t'(1);
        if (pre_r < nx) begin
          sxq_r  <= step_sxq;
          sxr_r  <= step_sxr;
          sxq0_r <= step_sxq;
          sxr0_r <= step_sxr;
        end
        if (pre_r < ny) begin
          syq_r <= step_syq;
          syr_r <= step_syr;
        end
      end
      ST_PIX: begin
        oaddr_r <= oaddr_pix;
        if (!covered) begin
          xcnt_r <= adv_x;
          ycnt_r <= adv_y;
          sxq_r  <= adv_sxq;
          sxr_r  <= adv_sxr;
          syq_r  <= adv_syq;
          syr_r  <= adv_syr;
          if (frame_end) li_r <= li_r + LIW'(1);
        end
      end
      ST_PWAIT: begin
        for (int k = 0; k < 3; k++) begin
          prod_r[k] <= 16'({8'd0, lay_q_r[8*k +: 8]} * {8'd0, lay_q_r[31:24]}) +
                       16'({8'd0, out_q_r[8*k +: 8]} * {8'd0, da});
        end
        prod_r[3] <= 16'({8'd0, out_q_r[31:24]} * {8'd0, da});
        src_r     <= lay_q_r;
        dst_r     <= out_q_r;
        sa_r      <= lay_q_r[31:24];
      end
      ST_PWB: begin
        xcnt_r <= adv_x;
        ycnt_r <= adv_y;
        sxq_r  <= adv_sxq;
        sxr_r  <= adv_sxr;
        syq_r  <= adv_syq;
        syr_r  <= adv_syr;
        if (frame_end) li_r <= li_r + LIW'(1);
      end
      default: ;
    endcase
  end

  assign rem_sh = {div_rem_r, (div_cnt_r == 4'd0)};
  assign da     = 8'd255 - lay_q_r[31:24];

  always_comb begin
    if (sa_r == 8'd255) begin
      blend_res = src_r;
    end else if (sa_r == 8'd0) begin
      blend_res = dst_r;
    end else begin
      blend_res = {sa_r + div255(prod_r[3]), div255(prod_r[2]), div255(prod_r[1]),
                   div255(prod_r[0])};
    end
  end

  // stores
  assign lwe    = (state_r == ST_CLEAR) || (state_r == ST_IDLE && pop && q_head.kind == K_WRITE);
  assign lwaddr = (state_r == ST_CLEAR) ? clr_r : laddr_cmd;
  assign lwdata = (state_r == ST_CLEAR) ? 32'd0 : q_head.pix;

  always_ff @(posedge clk) begin
    if (lwe) lmem[lwaddr] <= lwdata;
    lay_q_r <= lmem[laddr_pix];
  end

  assign owe    = (state_r == ST_OCLR) || (state_r == ST_PWB);
  assign owaddr = (state_r == ST_OCLR) ? oaddr_pix : oaddr_r;
  assign owdata = (state_r == ST_OCLR) ? 32'd0 : blend_res;
  assign oraddr = (state_r == ST_IDLE) ? oaddr_cmd : oaddr_pix;

  always_ff @(posedge clk) begin
    if (owe) omem[owaddr] <= owdata;
    out_q_r <= omem[oraddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (state_r == ST_RD) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_q_r;
        out_done_r  <= 1'b0;
      end else if (state_r == ST_DONE) begin
        out_valid_r <= 1'b1;
        out_data_r  <= 32'd0;
        out_done_r  <= 1'b1;
      end else if (state_r == ST_IDLE && pop && q_head.kind == K_ZERO) begin
        out_valid_r <= 1'b1;
        out_data_r  <= 32'd0;
        out_done_r  <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_done_r;

endmodule

### hdl/layer_alpha_compositor_unit.sv
// ============================================================================
// layer_alpha_compositor_unit: four-layer RGBA compositor, top level
// Input stream carries layer pixel writes, composite commands and output
// pixel reads; result stream carries read data and composite completion.
//
// Usage: write configuration on cfg_* (one register per cycle, while idle).
// in_tuser selects the operation; writes give no result. A read returns the
// output pixel (0 outside the frame) with out_tuser 0. A composite returns
// zero data with out_tuser 1 when the frame is finished.
// A pixel write updates the layer store as it leaves the queue. A read leaves
// the queue while its store word is read into a register, and that word then
// goes to the result register. A composite runs the divider and clears the
// output store, steps past each skipped layer, and per enabled layer runs
// setup, aligns for negative placed offsets dx, dy and walks the frame, each
// covered pixel read, blended and written back; then the result is posted.
// Reset: the layer stores are cleared one word per cycle, all
// LAYERS*MAX_LAYER_WIDTH*MAX_LAYER_HEIGHT words (262144 by default);
// in_tready stays low meanwhile. A two-entry queue decouples input from
// execution; when the receiver stalls, the result register holds and the
// queue keeps taking items until full.
// ============================================================================
module layer_alpha_compositor_unit #(
  parameter int LAYERS           = 4,
  parameter int MAX_LAYER_WIDTH  = 256,
  parameter int MAX_LAYER_HEIGHT = 256,
  parameter int MAX_OUT_WIDTH    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x, pos_y, pixel_in
  input  logic [3:0]  in_tuser,   // op, layer_sel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pixel_out
  output logic [0:0]  out_tuser,  // frame_done
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [42:0] cfg_wdata
);
  import lac_pkg::*;

  logic [8:0]  ow_r, oh_r;
  logic [15:0] zoom_r;
  logic [2:0]  wc_r;
  logic [DESC_COUNT-1:0][42:0] desc_r;

  cfg_t     cfg;
  cmd_t     q_head;
  logic     q_valid;
  bk_stat_t bk_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ow_r   <= 9'd256;
      oh_r   <= 9'd256;
      zoom_r <= 16'd256;
      wc_r   <= 3'd0;
      desc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUT_WIDTH:  ow_r <= cfg_wdata[8:0];
        CFG_OUT_HEIGHT: oh_r <= cfg_wdata[8:0];
        CFG_ZOOM: begin
          if (cfg_wdata[15:0] != 16'd0) zoom_r <= cfg_wdata[15:0];
        end
        CFG_WORLD:  wc_r      <= cfg_wdata[2:0];
        CFG_LAYER0: desc_r[0] <= cfg_wdata;
        CFG_LAYER1: desc_r[1] <= cfg_wdata;
        CFG_LAYER2: desc_r[2] <= cfg_wdata;
        CFG_LAYER3: desc_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.ow     = (int'(ow_r) > MAX_OUT_WIDTH) ? 9'(MAX_OUT_WIDTH) : ow_r;
    cfg.oh     = (int'(oh_r) > OUT_ROWS) ? 9'(OUT_ROWS) : oh_r;
    cfg.zoom   = zoom_r;
    cfg.wcount = wc_r;
    cfg.desc   = desc_r;
  end

  lac_front #(
    .LAYERS          (LAYERS),
    .MAX_LAYER_WIDTH (MAX_LAYER_WIDTH),
    .MAX_LAYER_HEIGHT(MAX_LAYER_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .ow       (cfg.ow),
    .oh       (cfg.oh),
    .bk_stat  (bk_stat),
    .q_head   (q_head),
    .q_valid  (q_valid)
  );

  lac_back #(
    .LAYERS          (LAYERS),
    .MAX_LAYER_WIDTH (MAX_LAYER_WIDTH),
    .MAX_LAYER_HEIGHT(MAX_LAYER_HEIGHT),
    .MAX_OUT_WIDTH   (MAX_OUT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_valid   (q_valid),
    .bk_stat   (bk_stat),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
